@@ rtl/tbop_pkg.sv @@
package tbop_pkg;

	localparam int SLOT_ID_W = 4;
	localparam int TIME_W = 48;
	localparam int MS_W = 32;
	localparam int MAX_EXPIRIES = 16;
	localparam int EXP_CNT_W = 5;

	typedef enum logic [1:0] {
		CMD_CREATE = 2'd0,
		CMD_SET = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_TICK = 2'd3
	} tbop_cmd_t;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_SET = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_EXPIRY = 2'd3
	} tbop_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CREATE,
		ST_REPLY,
		ST_TICK_INC,
		ST_TICK_RD,
		ST_TICK_CMP,
		ST_TICK_END
	} tbop_state_t;

	typedef struct packed {
		tbop_cmd_t cmd;
		logic [SLOT_ID_W-1:0] slot_id;
		logic [MS_W-1:0] initial_ms;
		logic [MS_W-1:0] period_ms;
	} tbop_req_t;

	typedef struct packed {
		tbop_kind_t kind;
		logic fail;
		logic [SLOT_ID_W-1:0] slot_out;
		logic last;
	} tbop_rsp_t;

endpackage

@@ rtl/tbop_ram.sv @@
module tbop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/timer_bank_oneshot_periodic_top.sv @@
// Channel | Handshake            | Word
// req     | req_valid, req_ready | tbop_req_t: cmd, slot_id, initial_ms, period_ms
// rsp     | rsp_valid, rsp_ready | tbop_rsp_t: kind, fail, slot_out, last
//
// Set time and delete go straight to the reply; create first scans the slots for a free one.
// A tick steps the millisecond count, then scans the expiry and
// period memories with their registered read and the one shared 48-bit adder.
// Reset clears the slot flags and the millisecond count at once; no clearing pass.
// A stalled rsp holds the scan only when a second expiry is found while one waits.
module timer_bank_oneshot_periodic_top
	import tbop_pkg::*;
#(
	parameter int TIMER_COUNT = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  tbop_req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output tbop_rsp_t rsp
);

	localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_COUNT - 1);
	localparam logic [6:0] COUNT7 = 7'(TIMER_COUNT);

	tbop_state_t state_q, state_d;

	logic [TIMER_COUNT-1:0] used_q;
	logic [TIMER_COUNT-1:0] armed_q;
	logic [TIME_W-1:0] now_q;
	logic [IW-1:0] idx_q;
	logic [EXP_CNT_W-1:0] n_q;
	logic pend_q;
	logic [SLOT_ID_W-1:0] pend_slot_q;
	logic rsp_valid_q;
	tbop_rsp_t rsp_q;

	tbop_cmd_t cmd_q;
	logic [MS_W-1:0] init_q;
	logic [MS_W-1:0] per_q;
	logic rep_fail_q;
	logic [SLOT_ID_W-1:0] rep_slot_q;
	logic [IW-1:0] rep_idx_q;

	logic accept;
	logic out_free;
	logic req_bad;
	logic [TIME_W-1:0] add_a, add_b, sum;
	logic [TIME_W-1:0] exp_rd;
	logic [MS_W-1:0] per_rd;
	logic slot_fire, cmp_go, cmp_stall;
	logic exp_we, per_we;
	logic [TIME_W-1:0] exp_wdata;
	logic [MS_W-1:0] per_wdata;
	logic [IW-1:0] waddr;
	logic ld_rsp;
	tbop_rsp_t rsp_d;
	logic rep_commit;

	assign accept = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_bad = ({3'b000, req.slot_id} >= COUNT7) || !used_q[IW'(req.slot_id)];
	assign sum = add_a + add_b;
	assign slot_fire = used_q[idx_q] && armed_q[idx_q] && (exp_rd <= now_q)
		&& (n_q < EXP_CNT_W'(MAX_EXPIRIES));
	assign cmp_stall = slot_fire && pend_q && !out_free;
	assign cmp_go = slot_fire && !cmp_stall;
	assign rep_commit = (state_q == ST_REPLY) && out_free && !rep_fail_q;

	tbop_ram #(.WIDTH(TIME_W), .DEPTH(TIMER_COUNT)) u_exp_ram (
		.clk(clk),
		.we(exp_we),
		.waddr(waddr),
		.wdata(exp_wdata),
		.raddr(idx_q),
		.rdata(exp_rd)
	);

	tbop_ram #(.WIDTH(MS_W), .DEPTH(TIMER_COUNT)) u_per_ram (
		.clk(clk),
		.we(per_we),
		.waddr(waddr),
		.wdata(per_wdata),
		.raddr(idx_q),
		.rdata(per_rd)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req.cmd)
						CMD_CREATE: state_d = ST_CREATE;
						CMD_TICK: state_d = ST_TICK_INC;
						default: state_d = ST_REPLY;
					endcase
				end
			end
			ST_CREATE: begin
				if (!used_q[idx_q] || (idx_q == LAST_IDX)) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK_INC: state_d = ST_TICK_RD;
			ST_TICK_RD: state_d = ST_TICK_CMP;
			ST_TICK_CMP: begin
				if (!cmp_stall) begin
					state_d = (idx_q == LAST_IDX) ? ST_TICK_END : ST_TICK_RD;
				end
			end
			ST_TICK_END: begin
				if (!pend_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == ST_IDLE);
		add_a = now_q;
		add_b = '0;
		exp_we = 1'b0;
		per_we = 1'b0;
		exp_wdata = sum;
		per_wdata = per_q;
		waddr = idx_q;
		ld_rsp = 1'b0;
		rsp_d = '{kind: KIND_EXPIRY, fail: 1'b0, slot_out: pend_slot_q, last: 1'b0};
		unique case (state_q)
			ST_REPLY: begin
				add_b = TIME_W'(init_q);
				waddr = rep_idx_q;
				if (rep_commit) begin
					if (cmd_q == CMD_CREATE) begin
						exp_we = 1'b1;
						per_we = 1'b1;
						exp_wdata = '0;
						per_wdata = '0;
					end else if (cmd_q == CMD_SET) begin
						exp_we = (init_q != '0);
						per_we = 1'b1;
					end
				end
				if (out_free) begin
					ld_rsp = 1'b1;
					rsp_d.fail = rep_fail_q;
					rsp_d.slot_out = rep_slot_q;
					rsp_d.last = 1'b1;
					unique case (cmd_q)
						CMD_CREATE: rsp_d.kind = KIND_CREATE;
						CMD_SET: rsp_d.kind = KIND_SET;
						CMD_DELETE: rsp_d.kind = KIND_DELETE;
						default: rsp_d.kind = KIND_EXPIRY;
					endcase
				end
			end
			ST_TICK_INC: begin
				add_b = TIME_W'(1);
			end
			ST_TICK_CMP: begin
				add_a = exp_rd;
				add_b = TIME_W'(per_rd);
				exp_we = cmp_go && (per_rd != '0);
				ld_rsp = cmp_go && pend_q;
			end
			ST_TICK_END: begin
				ld_rsp = pend_q && out_free;
				rsp_d.last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			armed_q <= '0;
			now_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				idx_q <= '0;
			end
			if ((state_q == ST_CREATE) && (state_d == ST_CREATE)) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rep_commit) begin
				unique case (cmd_q)
					CMD_CREATE: begin
						used_q[rep_idx_q] <= 1'b1;
						armed_q[rep_idx_q] <= 1'b0;
					end
					CMD_SET: armed_q[rep_idx_q] <= (init_q != '0);
					CMD_DELETE: begin
						used_q[rep_idx_q] <= 1'b0;
						armed_q[rep_idx_q] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_TICK_INC) begin
				now_q <= sum;
				idx_q <= '0;
				n_q <= '0;
			end
			if ((state_q == ST_TICK_CMP) && !cmp_stall) begin
				idx_q <= idx_q + 1'b1;
			end
			if ((state_q == ST_TICK_CMP) && cmp_go) begin
				if (per_rd == '0) begin
					armed_q[idx_q] <= 1'b0;
				end
				n_q <= n_q + 1'b1;
				pend_q <= 1'b1;
			end
			if ((state_q == ST_TICK_END) && out_free) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_rsp) begin
			rsp_q <= rsp_d;
		end
		if (accept) begin
			cmd_q <= req.cmd;
			init_q <= req.initial_ms;
			per_q <= req.period_ms;
			rep_fail_q <= req_bad;
			rep_slot_q <= req.slot_id;
			rep_idx_q <= IW'(req.slot_id);
		end
		if ((state_q == ST_CREATE) && (state_d == ST_REPLY)) begin
			rep_fail_q <= used_q[idx_q];
			rep_slot_q <= used_q[idx_q] ? '0 : SLOT_ID_W'(idx_q);
			rep_idx_q <= idx_q;
		end
		if ((state_q == ST_TICK_CMP) && cmp_go) begin
			pend_slot_q <= SLOT_ID_W'(idx_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

@@ rtl/tbop_checker.sv @@
module tbop_checker
	import tbop_pkg::*;
#(
	parameter int TIMER_COUNT = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input tbop_req_t req,
	input logic rsp_valid,
	input logic rsp_ready,
	input tbop_rsp_t rsp
);

	localparam logic [6:0] COUNT7 = 7'(TIMER_COUNT);

	// A waiting request word holds still until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request word changed while stalled");

	// A waiting response word holds still until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// Every command keeps the block busy in the cycle after it is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken back to back");

	// Replies end their command, and expiries never fail.
	a_rsp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.kind != KIND_EXPIRY) || !rsp.fail)
			&& ((rsp.kind == KIND_EXPIRY) || rsp.last))
		else $error("bad fail or last flag on response");

	// A granted slot lies inside the bank.
	a_create_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_CREATE) && !rsp.fail
			|-> ({3'b000, rsp.slot_out} < COUNT7))
		else $error("create granted a slot outside the bank");

endmodule

bind timer_bank_oneshot_periodic_top tbop_checker #(.TIMER_COUNT(TIMER_COUNT)) u_tbop_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp(rsp)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench
	import tbop_pkg::*;
();

	localparam int SLOTS = 16;
	localparam int RANDOM_WORDS = 92;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	tbop_req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	tbop_rsp_t rsp;

	tbop_req_t pending_words[$];
	tbop_rsp_t expected_rsp[$];
	int error_count = 0;
	int idle_cycles = 0;
	int req_gap = 0;
	int rsp_gap = 0;
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;
	tbop_rsp_t want;

	// Allocation view used only while building the stimulus.
	bit alloc_view[SLOTS];

	// Predicted state of the timer bank.
	bit slot_taken[SLOTS];
	bit slot_armed[SLOTS];
	logic [TIME_W-1:0] slot_due[SLOTS];
	logic [MS_W-1:0] slot_period[SLOTS];
	logic [TIME_W-1:0] ms_count;

	timer_bank_oneshot_periodic_top #(
		.TIMER_COUNT(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic tbop_rsp_t make_rsp(input tbop_kind_t k, input logic f,
			input logic [SLOT_ID_W-1:0] s, input logic l);
		tbop_rsp_t r;
		r.kind = k;
		r.fail = f;
		r.slot_out = s;
		r.last = l;
		return r;
	endfunction

	task automatic predict_bank(input tbop_req_t w);
		bit found;
		bit held_valid;
		int n;
		tbop_rsp_t held;
		found = 1'b0;
		held_valid = 1'b0;
		n = 0;
		held = '0;
		case (w.cmd)
			CMD_CREATE: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !slot_taken[i]) begin
						found = 1'b1;
						slot_taken[i] = 1'b1;
						slot_armed[i] = 1'b0;
						slot_period[i] = '0;
						slot_due[i] = '0;
						expected_rsp.push_back(make_rsp(KIND_CREATE, 1'b0, i[SLOT_ID_W-1:0], 1'b1));
					end
				end
				if (!found)
					expected_rsp.push_back(make_rsp(KIND_CREATE, 1'b1, '0, 1'b1));
			end
			CMD_SET, CMD_DELETE: begin
				if (!slot_taken[w.slot_id]) begin
					expected_rsp.push_back(make_rsp(w.cmd == CMD_SET ? KIND_SET : KIND_DELETE,
						1'b1, w.slot_id, 1'b1));
				end else if (w.cmd == CMD_SET) begin
					slot_period[w.slot_id] = w.period_ms;
					if (w.initial_ms != '0) begin
						slot_armed[w.slot_id] = 1'b1;
						slot_due[w.slot_id] = ms_count + TIME_W'(w.initial_ms);
					end else begin
						slot_armed[w.slot_id] = 1'b0;
					end
					expected_rsp.push_back(make_rsp(KIND_SET, 1'b0, w.slot_id, 1'b1));
				end else begin
					slot_taken[w.slot_id] = 1'b0;
					slot_armed[w.slot_id] = 1'b0;
					expected_rsp.push_back(make_rsp(KIND_DELETE, 1'b0, w.slot_id, 1'b1));
				end
			end
			default: begin
				ms_count = ms_count + 1'b1;
				for (int i = 0; i < SLOTS; i++) begin
					if (n < MAX_EXPIRIES && slot_taken[i] && slot_armed[i]
							&& slot_due[i] <= ms_count) begin
						if (held_valid)
							expected_rsp.push_back(held);
						held = make_rsp(KIND_EXPIRY, 1'b0, i[SLOT_ID_W-1:0], 1'b0);
						held_valid = 1'b1;
						n++;
						if (slot_period[i] != '0)
							slot_due[i] = slot_due[i] + TIME_W'(slot_period[i]);
						else
							slot_armed[i] = 1'b0;
					end
				end
				if (held_valid) begin
					held.last = 1'b1;
					expected_rsp.push_back(held);
				end
			end
		endcase
	endtask

	task automatic queue_word(input tbop_cmd_t c, input logic [SLOT_ID_W-1:0] id,
			input logic [MS_W-1:0] ini, input logic [MS_W-1:0] per);
		tbop_req_t w;
		bit found;
		found = 1'b0;
		w.cmd = c;
		w.slot_id = id;
		w.initial_ms = ini;
		w.period_ms = per;
		pending_words.push_back(w);
		if (c == CMD_CREATE) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && !alloc_view[i]) begin
					found = 1'b1;
					alloc_view[i] = 1'b1;
				end
			end
		end else if (c == CMD_DELETE) begin
			alloc_view[id] = 1'b0;
		end
	endtask

	function automatic logic [SLOT_ID_W-1:0] pick_used_slot();
		int used_list[$];
		for (int i = 0; i < SLOTS; i++)
			if (alloc_view[i])
				used_list.push_back(i);
		if (used_list.size() == 0)
			return SLOT_ID_W'($urandom_range(0, SLOTS - 1));
		return SLOT_ID_W'(used_list[$urandom_range(0, used_list.size() - 1)]);
	endfunction

	function automatic logic [MS_W-1:0] pick_delay();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 85)
			return MS_W'($urandom_range(1, 6));
		return $urandom;
	endfunction

	function automatic logic [MS_W-1:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return '0;
		if (r < 85)
			return MS_W'($urandom_range(1, 4));
		return $urandom;
	endfunction

	initial begin
		int r;
		for (int i = 0; i < SLOTS; i++) begin
			alloc_view[i] = 1'b0;
			slot_taken[i] = 1'b0;
			slot_armed[i] = 1'b0;
			slot_due[i] = '0;
			slot_period[i] = '0;
		end
		ms_count = '0;

		// Fill the bank, then one more create finds it full.
		for (int i = 0; i <= SLOTS; i++)
			queue_word(CMD_CREATE, SLOT_ID_W'($urandom_range(0, SLOTS - 1)), $urandom, $urandom);
		queue_word(CMD_SET, 4'd0, 32'd1, 32'd0);
		queue_word(CMD_SET, 4'd1, 32'd1, 32'd1);
		queue_word(CMD_SET, 4'd2, 32'd0, 32'd5);
		queue_word(CMD_SET, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(CMD_TICK, 4'd0, 32'd0, 32'd0);
		queue_word(CMD_TICK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(CMD_DELETE, 4'd1, 32'd0, 32'd0);
		queue_word(CMD_DELETE, 4'd1, 32'd0, 32'd0);
		queue_word(CMD_SET, 4'd1, 32'd3, 32'd0);
		queue_word(CMD_CREATE, 4'd0, 32'd0, 32'd0);
		queue_word(CMD_TICK, 4'd0, 32'd0, 32'd0);

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				queue_word(CMD_CREATE, SLOT_ID_W'($urandom_range(0, SLOTS - 1)),
					$urandom, $urandom);
			else if (r < 40)
				queue_word(CMD_SET, pick_used_slot(), pick_delay(), pick_period());
			else if (r < 50)
				queue_word(CMD_DELETE, pick_used_slot(), $urandom, $urandom);
			else if (r < 58)
				queue_word(r < 54 ? CMD_SET : CMD_DELETE,
					SLOT_ID_W'($urandom_range(0, SLOTS - 1)), $urandom, $urandom);
			else
				queue_word(CMD_TICK, SLOT_ID_W'($urandom_range(0, SLOTS - 1)),
					$urandom, $urandom);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (error_count == 0 && expected_rsp.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			req_gap = 0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				req_calm = !req_calm;
			if (req_valid && req_ready)
				predict_bank(req);
			if (!req_valid || req_ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					req <= pending_words.pop_front();
					req_valid <= 1'b1;
					req_gap = req_calm ? 0 : pick_gap();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_gap = 0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				rsp_calm = !rsp_calm;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					flag_error($sformatf("unexpected word kind=%0d fail=%0d slot=%0d last=%0d",
						rsp.kind, rsp.fail, rsp.slot_out, rsp.last));
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.kind !== want.kind)
						flag_error($sformatf("kind %0d, expected %0d", rsp.kind, want.kind));
					if (rsp.fail !== want.fail)
						flag_error($sformatf("fail %0d, expected %0d", rsp.fail, want.fail));
					if (rsp.slot_out !== want.slot_out)
						flag_error($sformatf("slot_out %0d, expected %0d",
							rsp.slot_out, want.slot_out));
					if (rsp.last !== want.last)
						flag_error($sformatf("last %0d, expected %0d", rsp.last, want.last));
				end
				rsp_gap = rsp_calm ? 0 : pick_gap();
			end
			if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

endmodule

@@ timer_bank_oneshot_periodic_top.f @@
rtl/tbop_pkg.sv
rtl/tbop_ram.sv
rtl/timer_bank_oneshot_periodic_top.sv
rtl/tbop_checker.sv
tb/testbench.sv
